/* rtl/core/lss_pkg.sv */
// Package for the LED strip frame serializer: sizes, codes and shared types.
// Used by every module under rtl/core except lss_ram; depends on nothing.
package lss_pkg;

    localparam int MAX_PIXELS   = 512;
    localparam int RESET_PIXELS = (MAX_PIXELS < 32) ? MAX_PIXELS : 32;
    localparam int PIX_AW       = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int MAX_TOTAL    = 3 * MAX_PIXELS + (MAX_PIXELS + 31) / 32;
    localparam int POS_W        = $clog2(MAX_TOTAL + 1);
    localparam int PIX_W        = $clog2(MAX_TOTAL / 3 + 2);
    localparam int CNT_W        = 10;
    localparam int ROW_W        = 24;
    localparam int PADDR_W      = 3;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0]       OFF_BYTE  = 8'h80;
    localparam logic [ROW_W-1:0] OFF_ROW   = {OFF_BYTE, OFF_BYTE, OFF_BYTE};
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PIXELS);
    localparam logic [CNT_W-1:0] RST_COUNT = CNT_W'(RESET_PIXELS);

    localparam logic [PADDR_W-3:0] REG_LED_COUNT = '0;

    typedef enum logic [1:0] {
        CMD_INDEX = 2'd0,
        CMD_COLOR = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_SLOT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_RANGE    = 2'd1,
        ST_BYTE     = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_ACK,
        OP_REJECT,
        OP_WRITE,
        OP_FLUSH,
        OP_SLOT
    } t_op;

    typedef enum logic {
        BK_CLEAR,
        BK_RUN
    } t_back_state;

    typedef struct packed {
        t_op               op;
        logic [PIX_AW-1:0] index;
        logic [ROW_W-1:0]  row;
    } t_op_entry;

    typedef struct packed {
        t_status    status;
        logic [7:0] out_byte;
        logic       last_byte;
    } t_result;

endpackage

/* rtl/core/lss_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lss_front.sv */
// Front end: accepts host and byte-slot requests, pairs index and color.
// Depends on lss_pkg; feeds lss_queue.
module lss_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_enable,
    input  logic [lss_pkg::CNT_W-1:0]    i_led_count,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_command,
    input  logic [9:0]                   i_pixel_index,
    input  logic [7:0]                   i_red,
    input  logic [7:0]                   i_green,
    input  logic [7:0]                   i_blue,
    input  logic                         i_q_full,
    output logic                         o_push,
    output lss_pkg::t_op_entry           o_entry
);
    import lss_pkg::*;

    logic [PIX_AW-1:0] r_held_index, n_held_index;
    logic              r_index_valid, n_index_valid;
    logic [ROW_W-1:0]  r_held_row, n_held_row;
    logic              r_row_valid, n_row_valid;
    logic              w_accept;
    logic [ROW_W-1:0]  w_row;
    t_cmd              w_cmd;

    assign o_in_ready = i_enable && !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = w_accept;
    assign w_cmd      = t_cmd'(i_command);
    assign w_row      = {i_green | OFF_BYTE, i_red | OFF_BYTE, i_blue | OFF_BYTE};

    always_comb begin
        n_held_index  = r_held_index;
        n_index_valid = r_index_valid;
        n_held_row    = r_held_row;
        n_row_valid   = r_row_valid;
        o_entry.op    = OP_ACK;
        o_entry.index = r_held_index;
        o_entry.row   = r_held_row;
        if (w_accept) begin
            unique case (w_cmd)
                CMD_INDEX: begin
                    if ({1'b0, i_pixel_index} >= {1'b0, i_led_count}) begin
                        o_entry.op = OP_REJECT;
                    end else if (r_row_valid) begin
                        o_entry.op    = OP_WRITE;
                        o_entry.index = PIX_AW'(i_pixel_index);
                        n_row_valid   = 1'b0;
                        n_index_valid = 1'b0;
                    end else begin
                        n_held_index  = PIX_AW'(i_pixel_index);
                        n_index_valid = 1'b1;
                    end
                end
                CMD_COLOR: begin
                    if (r_index_valid) begin
                        o_entry.op    = OP_WRITE;
                        o_entry.row   = w_row;
                        n_row_valid   = 1'b0;
                        n_index_valid = 1'b0;
                    end else begin
                        n_held_row  = w_row;
                        n_row_valid = 1'b1;
                    end
                end
                CMD_FLUSH: o_entry.op = OP_FLUSH;
                CMD_SLOT:  o_entry.op = OP_SLOT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_valid <= 1'b0;
            r_row_valid   <= 1'b0;
        end else begin
            r_index_valid <= n_index_valid;
            r_row_valid   <= n_row_valid;
        end
        r_held_index <= n_held_index;
        r_held_row   <= n_held_row;
    end

endmodule

/* rtl/core/lss_queue.sv */
// Short request queue between the front end and the serializer back end.
// Depends on lss_pkg.
module lss_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lss_pkg::t_op_entry i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output lss_pkg::t_op_entry o_entry
);
    import lss_pkg::*;

    localparam int QA_W = $clog2(QUEUE_DEPTH);

    t_op_entry       r_slot [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QA_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QA_W:0]   r_count, n_count;

    assign o_full  = (r_count == (QA_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? QA_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = i_pop ? QA_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* rtl/core/lss_back.sv */
// Back end: frame store clearing, pixel writes, transfer sequencing, byte output.
// Depends on lss_pkg and lss_ram.
module lss_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lss_pkg::CNT_W-1:0] i_led_count,
    input  logic                      i_q_valid,
    input  lss_pkg::t_op_entry        i_q_entry,
    output logic                      o_pop,
    output logic                      o_clearing,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output lss_pkg::t_result          o_result
);
    import lss_pkg::*;

    localparam int WIDE_W = POS_W + 6;

    t_back_state       r_state, n_state;
    logic [PIX_AW-1:0] r_clr_addr, n_clr_addr;
    logic              r_busy, n_busy;
    logic              r_flush_wait, n_flush_wait;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [PIX_W-1:0]  r_pix, n_pix;
    logic [1:0]        r_sub, n_sub;

    logic              r_s1_valid, n_s1_valid;
    t_result           r_s1_res, n_s1_res;
    logic [1:0]        r_s1_sel, n_s1_sel;
    logic              r_s1_ram, n_s1_ram;
    logic              r_out_valid, n_out_valid;
    t_result           r_out_res, n_out_res;

    logic              w_s1_move;
    logic              w_we, w_re;
    logic [PIX_AW-1:0] w_waddr;
    logic [ROW_W-1:0]  w_wdata;
    logic [ROW_W-1:0]  w_rdata;
    logic [7:0]        w_sel_byte;
    logic [WIDE_W-1:0] w_pc_wide;
    logic [POS_W-1:0]  w_data_bytes, w_total, w_pos_inc;

    lss_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (PIX_AW'(r_pix)),
        .o_rdata (w_rdata)
    );

    assign w_pc_wide    = WIDE_W'(i_led_count);
    assign w_data_bytes = POS_W'((w_pc_wide << 1) + w_pc_wide);
    assign w_total      = POS_W'((w_pc_wide << 1) + w_pc_wide
                                 + ((w_pc_wide + WIDE_W'(31)) >> 5));
    assign w_pos_inc    = POS_W'(r_pos + 1'b1);

    assign o_clearing  = (r_state == BK_CLEAR);
    assign w_s1_move   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_pop       = i_q_valid && (r_state == BK_RUN) && (!r_s1_valid || w_s1_move);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_res;

    always_comb begin
        case (r_s1_sel)
            2'd0:    w_sel_byte = w_rdata[23:16];
            2'd1:    w_sel_byte = w_rdata[15:8];
            default: w_sel_byte = w_rdata[7:0];
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_busy       = r_busy;
        n_flush_wait = r_flush_wait;
        n_pos        = r_pos;
        n_pix        = r_pix;
        n_sub        = r_sub;
        n_s1_valid   = r_s1_valid;
        n_s1_res     = r_s1_res;
        n_s1_sel     = r_s1_sel;
        n_s1_ram     = r_s1_ram;
        n_out_valid  = r_out_valid;
        n_out_res    = r_out_res;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_waddr      = i_q_entry.index;
        w_wdata      = i_q_entry.row;

        unique case (r_state)
            BK_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = OFF_ROW;
                n_clr_addr = PIX_AW'(r_clr_addr + 1'b1);
                if (r_clr_addr == PIX_AW'(MAX_PIXELS - 1)) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: ;
        endcase

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_s1_move) begin
            n_out_valid = 1'b1;
            n_out_res   = r_s1_res;
            if (r_s1_ram) begin
                n_out_res.out_byte = w_sel_byte;
            end
            n_s1_valid = 1'b0;
        end

        if (o_pop) begin
            n_s1_valid = 1'b1;
            n_s1_res   = '{status: ST_ACCEPTED, out_byte: 8'd0, last_byte: 1'b0};
            n_s1_ram   = 1'b0;
            n_s1_sel   = r_sub;
            unique case (i_q_entry.op)
                OP_ACK:    ;
                OP_REJECT: n_s1_res.status = ST_RANGE;
                OP_WRITE:  w_we = 1'b1;
                OP_FLUSH: begin
                    if (r_busy) begin
                        n_flush_wait = 1'b1;
                    end else begin
                        n_busy = 1'b1;
                        n_pos  = '0;
                        n_pix  = '0;
                        n_sub  = '0;
                    end
                end
                OP_SLOT: begin
                    if (!r_busy) begin
                        n_s1_res.status = ST_IDLE;
                    end else if (r_pos >= w_total) begin
                        n_s1_res.status = ST_IDLE;
                        n_busy          = r_flush_wait;
                        n_flush_wait    = 1'b0;
                        if (r_flush_wait) begin
                            n_pos = '0;
                            n_pix = '0;
                            n_sub = '0;
                        end
                    end else begin
                        n_s1_res.status = ST_BYTE;
                        if (r_pos < w_data_bytes) begin
                            w_re     = 1'b1;
                            n_s1_ram = 1'b1;
                        end
                        n_pos = w_pos_inc;
                        if (r_sub == 2'd2) begin
                            n_sub = '0;
                            n_pix = PIX_W'(r_pix + 1'b1);
                        end else begin
                            n_sub = r_sub + 1'b1;
                        end
                        if (w_pos_inc == w_total) begin
                            n_s1_res.last_byte = 1'b1;
                            n_busy             = r_flush_wait;
                            n_flush_wait       = 1'b0;
                            if (r_flush_wait) begin
                                n_pos = '0;
                                n_pix = '0;
                                n_sub = '0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_CLEAR;
            r_clr_addr   <= '0;
            r_busy       <= 1'b1;
            r_flush_wait <= 1'b0;
            r_pos        <= POS_W'(3 * RESET_PIXELS);
            r_pix        <= PIX_W'(RESET_PIXELS);
            r_sub        <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_busy       <= n_busy;
            r_flush_wait <= n_flush_wait;
            r_pos        <= n_pos;
            r_pix        <= n_pix;
            r_sub        <= n_sub;
            r_s1_valid   <= n_s1_valid;
            r_out_valid  <= n_out_valid;
        end
        r_s1_res  <= n_s1_res;
        r_s1_sel  <= n_s1_sel;
        r_s1_ram  <= n_s1_ram;
        r_out_res <= n_out_res;
    end

endmodule

/* rtl/core/led_strip_frame_serializer.sv */
// Top level of the LED strip frame serializer: config register and block wiring.
// Depends on lss_pkg, lss_front, lss_queue, lss_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   request  | i_in_valid/o_in_ready  | i_command i_pixel_index i_red i_green i_blue
//   result   | o_out_valid/i_out_ready| o_status o_out_byte o_last_byte
//   config   | psel penable pwrite    | paddr pwdata prdata (pready tied high)
//
// One request per cycle sustained while results are taken; a result passes through the
// queue entry, the store read stage and the output register after its request is accepted.
// Byte reads use the frame store's registered read port. After reset a clearing pass
// writes the store one pixel row per cycle, over all MAX_PIXELS rows, before any request is
// taken. A stalled result side backs up into the four-entry queue; requests keep
// flowing until it fills.
module led_strip_frame_serializer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic [9:0]                    i_pixel_index,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last_byte,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lss_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lss_pkg::*;

    logic [CNT_W-1:0] r_led_count, n_led_count;
    logic             w_cfg_wr;
    logic             w_clearing;
    logic             w_push, w_pop, w_q_full, w_q_valid;
    t_op_entry        w_push_entry, w_head_entry;
    t_result          w_result;

    assign pready   = 1'b1;
    assign prdata   = 32'(r_led_count);
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[PADDR_W-1:2] == REG_LED_COUNT);

    always_comb begin
        n_led_count = r_led_count;
        if (w_cfg_wr) begin
            n_led_count = (pwdata[CNT_W-1:0] > MAX_COUNT) ? MAX_COUNT
                                                          : pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= RST_COUNT;
        end else begin
            r_led_count <= n_led_count;
        end
    end

    lss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (!w_clearing),
        .i_led_count   (r_led_count),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_pixel_index (i_pixel_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    lss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_head_entry)
    );

    lss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_led_count   (r_led_count),
        .i_q_valid     (w_q_valid),
        .i_q_entry     (w_head_entry),
        .o_pop         (w_pop),
        .o_clearing    (w_clearing),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result      (w_result)
    );

    assign o_status    = w_result.status;
    assign o_out_byte  = w_result.out_byte;
    assign o_last_byte = w_result.last_byte;

endmodule
